@@ rtl/text_cell_glyph_renderer_unit_defines.svh @@
// Assertion macros for the text cell glyph renderer checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH
`define TEXT_CELL_GLYPH_RENDERER_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TCGR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

@@ rtl/tcgr_pkg.sv @@
// Shared types, constants and helpers of the text cell glyph renderer.
// No dependencies.
`default_nettype none

package tcgr_pkg;

	localparam int GLYPH_ROWS  = 16;
	localparam int GLYPH_COUNT = 512;
	localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW     = $clog2(FONT_DEPTH);
	localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
	localparam int LINE_W      = $clog2(GLYPH_ROWS);
	localparam int FADDR_IN_W  = 13;
	// one spare bit so the font depth itself fits for the range compare
	localparam int FADDR_EXT_W = ((FONT_AW > FADDR_IN_W) ? FONT_AW : FADDR_IN_W) + 1;
	localparam int PY_FULL_W   = 8 + LINE_W + 1;

	typedef enum logic [1:0] {
		FUNC_RENDER  = 2'd0,
		FUNC_FONT_WR = 2'd1,
		FUNC_PAL_WR  = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	localparam logic CFG_EXT_FONT = 1'b0;
	localparam logic CFG_BLINK    = 1'b1;

	typedef struct packed {
		logic              capture;  // latch render fields
		logic              font_we;
		logic              pal_we;
		logic              pal_rd;   // fetch fg/bg entries
		logic              font_rd;  // fetch one glyph line
		logic [LINE_W-1:0] line;
	} tcgr_cmd_t;

	// standard 16-color 6-bit DAC palette, red 17:12, green 11:6, blue 5:0
	function automatic logic [17:0] pal_default(input logic [3:0] idx);
		logic [17:0] e;
		case (idx)
			4'd0:    e = {6'h00, 6'h00, 6'h00};
			4'd1:    e = {6'h00, 6'h00, 6'h2A};
			4'd2:    e = {6'h00, 6'h2A, 6'h00};
			4'd3:    e = {6'h00, 6'h2A, 6'h2A};
			4'd4:    e = {6'h2A, 6'h00, 6'h00};
			4'd5:    e = {6'h2A, 6'h00, 6'h2A};
			4'd6:    e = {6'h2A, 6'h15, 6'h00};
			4'd7:    e = {6'h2A, 6'h2A, 6'h2A};
			4'd8:    e = {6'h15, 6'h15, 6'h15};
			4'd9:    e = {6'h15, 6'h15, 6'h3F};
			4'd10:   e = {6'h15, 6'h3F, 6'h15};
			4'd11:   e = {6'h15, 6'h3F, 6'h3F};
			4'd12:   e = {6'h3F, 6'h15, 6'h15};
			4'd13:   e = {6'h3F, 6'h15, 6'h3F};
			4'd14:   e = {6'h3F, 6'h3F, 6'h15};
			default: e = {6'h3F, 6'h3F, 6'h3F};
		endcase
		return e;
	endfunction

	// 6:6:6 DAC entry to 8:8:8 RGB, each channel times 4
	function automatic logic [23:0] entry_to_rgb(input logic [17:0] e);
		return {e[17:12], 2'b00, e[11:6], 2'b00, e[5:0], 2'b00};
	endfunction

endpackage

`default_nettype wire

@@ rtl/tcgr_ctrl.sv @@
// Sequencer of the glyph renderer: accepts items, steps through glyph lines.
// Depends on tcgr_pkg.
`default_nettype none

module tcgr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        func,
	output logic                   busy,
	output tcgr_pkg::tcgr_cmd_t    cmd
);
	import tcgr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_ROWS = 3'b100
	} state_t;

	state_t            state_q;
	logic [LINE_W-1:0] line_q;
	logic              accept;
	logic              line_end;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign line_end = (line_q == LINE_W'(GLYPH_ROWS - 1));

	always_comb begin
		cmd         = '0;
		cmd.capture = accept && (func_t'(func) == FUNC_RENDER);
		cmd.font_we = accept && (func_t'(func) == FUNC_FONT_WR);
		cmd.pal_we  = accept && (func_t'(func) == FUNC_PAL_WR);
		cmd.pal_rd  = (state_q == ST_LOAD);
		cmd.font_rd = (state_q == ST_ROWS);
		cmd.line    = line_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					line_q <= '0;
					if (cmd.capture) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (line_end) begin
						line_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						line_q <= line_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					line_q  <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcgr_datapath.sv @@
// Font memory, palette memory, mode registers and row result registers.
// Depends on tcgr_pkg; driven by tcgr_ctrl commands.
`default_nettype none

module tcgr_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tcgr_pkg::tcgr_cmd_t cmd,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic                cfg_data,
	input  wire logic [7:0]          char_code,
	input  wire logic [7:0]          attribute,
	input  wire logic [7:0]          column,
	input  wire logic [7:0]          row,
	input  wire logic                blink_phase,
	input  wire logic [12:0]         font_address,
	input  wire logic [7:0]          font_byte,
	input  wire logic [3:0]          palette_index,
	input  wire logic [5:0]          palette_red,
	input  wire logic [5:0]          palette_green,
	input  wire logic [5:0]          palette_blue,
	output logic                     strobe,
	output logic [10:0]              pixel_x,
	output logic [11:0]              pixel_y,
	output logic [7:0]               glyph_bits,
	output logic [23:0]              foreground_rgb,
	output logic [23:0]              background_rgb,
	output logic                     last
);
	import tcgr_pkg::*;

	// mode registers
	logic ext_font_q;
	logic blink_mode_q;

	// latched render item
	logic [7:0] char_q;
	logic [7:0] attr_q;
	logic [7:0] col_q;
	logic [7:0] row_q;
	logic       phase_q;

	// memories
	logic [7:0]  font_mem [FONT_DEPTH];
	logic [17:0] pal_mem  [16];
	logic [15:0] pal_vld_q;

	logic [17:0] pal_f_q, pal_b_q;
	logic        pal_fv_q, pal_bv_q;
	logic        blink_q;

	logic [7:0]        font_s1;
	logic              strobe_s1;
	logic [LINE_W-1:0] line_s1;

	logic [FADDR_EXT_W-1:0] wr_addr;
	logic                   wr_ok;
	logic [GLYPH_W+1:0]     glyph_full;
	logic [GLYPH_W+1:0]     glyph_wrap;
	logic [FONT_AW-1:0]     rd_addr;
	logic [3:0]             fidx, bidx;
	logic [17:0]            fg_entry, bg_entry;
	logic [PY_FULL_W-1:0]   py_full;

	assign wr_addr = FADDR_EXT_W'(font_address);
	assign wr_ok   = (wr_addr < FADDR_EXT_W'(FONT_DEPTH));

	// upper bank adds 256, then wrap into the font
	assign glyph_full = (GLYPH_W + 2)'({ext_font_q && attr_q[3], char_q});
	assign glyph_wrap = (glyph_full >= (GLYPH_W + 2)'(GLYPH_COUNT))
		? glyph_full - (GLYPH_W + 2)'(GLYPH_COUNT) : glyph_full;
	assign rd_addr = FONT_AW'(glyph_wrap[GLYPH_W-1:0]) * FONT_AW'(GLYPH_ROWS)
		+ FONT_AW'(cmd.line);

	assign fidx = ext_font_q   ? {1'b0, attr_q[2:0]} : attr_q[3:0];
	assign bidx = blink_mode_q ? {1'b0, attr_q[6:4]} : attr_q[7:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_font_q   <= 1'b0;
			blink_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXT_FONT: ext_font_q   <= cfg_data;
				CFG_BLINK:    blink_mode_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q  <= char_code;
			attr_q  <= attribute;
			col_q   <= column;
			row_q   <= row;
			phase_q <= blink_phase;
		end
	end

	// font store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.font_we && wr_ok) font_mem[wr_addr[FONT_AW-1:0]] <= font_byte;
		if (cmd.font_rd) font_s1 <= font_mem[rd_addr];
	end

	// palette store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.pal_we) pal_mem[palette_index] <= {palette_red, palette_green, palette_blue};
		if (cmd.pal_rd) begin
			pal_f_q <= pal_mem[fidx];
			pal_b_q <= pal_mem[bidx];
			blink_q <= phase_q && blink_mode_q && attr_q[7];
		end
	end

	// unwritten palette entries read as the default palette
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
			pal_fv_q  <= 1'b0;
			pal_bv_q  <= 1'b0;
		end else begin
			if (cmd.pal_we) pal_vld_q[palette_index] <= 1'b1;
			if (cmd.pal_rd) begin
				pal_fv_q <= pal_vld_q[fidx];
				pal_bv_q <= pal_vld_q[bidx];
			end
		end
	end

	// default entry is looked up at the latched indices, stable while rendering
	assign fg_entry = pal_fv_q ? pal_f_q : pal_default(fidx);
	assign bg_entry = pal_bv_q ? pal_b_q : pal_default(bidx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
			line_s1   <= '0;
		end else begin
			strobe_s1 <= cmd.font_rd;
			if (cmd.font_rd) line_s1 <= cmd.line;
		end
	end

	assign py_full = PY_FULL_W'(row_q) * PY_FULL_W'(GLYPH_ROWS) + PY_FULL_W'(line_s1);

	assign strobe         = strobe_s1;
	assign glyph_bits     = font_s1;
	assign pixel_x        = {col_q, 3'b000};
	assign pixel_y        = py_full[11:0];
	assign background_rgb = entry_to_rgb(bg_entry);
	assign foreground_rgb = blink_q ? entry_to_rgb(bg_entry) : entry_to_rgb(fg_entry);
	assign last           = (line_s1 == LINE_W'(GLYPH_ROWS - 1));

endmodule

`default_nettype wire

@@ rtl/text_cell_glyph_renderer_unit.sv @@
// Render item: accepted at start && !busy; first row strobe after LOAD and the
// registered font read in ROWS, then one row per cycle for 16 rows; next item taken
// once the sequencer is back in IDLE. Rate is set by the single font read port, one
// glyph line a cycle. Font and palette writes emit nothing. Results cannot stall.
// Reset (arst_n low) clears the sequencer, mode registers and palette valid bits;
// the palette reads as the default palette until written, the font is not cleared.
`default_nettype none

module text_cell_glyph_renderer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  attribute,
	input  wire logic [7:0]  column,
	input  wire logic [7:0]  row,
	input  wire logic        blink_phase,
	input  wire logic [12:0] font_address,
	input  wire logic [7:0]  font_byte,
	input  wire logic [3:0]  palette_index,
	input  wire logic [5:0]  palette_red,
	input  wire logic [5:0]  palette_green,
	input  wire logic [5:0]  palette_blue,
	// register write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	// row results, one beat per strobe cycle
	output logic             strobe,
	output logic [10:0]      pixel_x,
	output logic [11:0]      pixel_y,
	output logic [7:0]       glyph_bits,
	output logic [23:0]      foreground_rgb,
	output logic [23:0]      background_rgb,
	output logic             last
);
	import tcgr_pkg::*;

	tcgr_cmd_t cmd;

	// mode registers are always writable; writes land only while idle by contract
	assign cfg_ready = 1'b1;

	// sequencer: IDLE -> LOAD (palette fetch) -> ROWS (one glyph line a cycle)
	tcgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.busy   (busy),
		.cmd    (cmd)
	);

	// stores and result registers; glyph row leaves in the cycle after its read
	tcgr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.char_code      (char_code),
		.attribute      (attribute),
		.column         (column),
		.row            (row),
		.blink_phase    (blink_phase),
		.font_address   (font_address),
		.font_byte      (font_byte),
		.palette_index  (palette_index),
		.palette_red    (palette_red),
		.palette_green  (palette_green),
		.palette_blue   (palette_blue),
		.strobe         (strobe),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.glyph_bits     (glyph_bits),
		.foreground_rgb (foreground_rgb),
		.background_rgb (background_rgb),
		.last           (last)
	);

endmodule

`default_nettype wire

@@ rtl/tcgr_checker.sv @@
// Port-level checks of the glyph renderer's row sequencing, bound to the top.
// Depends on text_cell_glyph_renderer_unit_defines.svh and tcgr_pkg.
`default_nettype none
`include "text_cell_glyph_renderer_unit_defines.svh"

module tcgr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] func,
	input wire logic       strobe,
	input wire logic       last
);
	import tcgr_pkg::*;

	logic render_acc;
	assign render_acc = start && !busy && (func_t'(func) == FUNC_RENDER);

	// first row is on the ports after the LOAD state, the first ROWS state and the font read register
	`TCGR_ASSERT_NEXT(a_render_busy, render_acc, busy, "render accepted but busy low")
	`TCGR_ASSERT_NOW(a_first_row, render_acc, ##3 strobe, "first row not three edges after start")
	`TCGR_ASSERT_NEXT(a_rows_contig, strobe && !last, strobe, "gap inside a cell's rows")
	`TCGR_ASSERT_NEXT(a_last_ends, strobe && last, !strobe, "row beat after last")
	`TCGR_ASSERT_NOW(a_busy_mid, strobe && !last, busy, "idle while rows pending")

endmodule

bind text_cell_glyph_renderer_unit tcgr_checker u_tcgr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.strobe (strobe),
	.last   (last)
);

`default_nettype wire
